[rtl/core/curve_segment_evaluator_top_assert.svh]
// Assertion macros for the curve segment evaluator.
`ifndef CURVE_SEGMENT_EVALUATOR_TOP_ASSERT_SVH
`define CURVE_SEGMENT_EVALUATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define CSE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cse assertion failed");
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
	`CSE_ASSERT(lbl, (ante) |=> (cons))
`else
`define CSE_ASSERT(lbl, prop)
`define CSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/cse_pkg.sv]
package cse_pkg;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int T_W = 17;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << PARAM_FRAC_BITS;

	localparam int D_W = COORD_W + 1;
	localparam int M_W = D_W + T_W + 1;
	localparam int TT_W = 2 * T_W;
	localparam int W_W = PARAM_FRAC_BITS + 5;
	localparam int P_W = W_W + COORD_W;
	localparam int S_W = P_W + 2;

	localparam logic signed [W_W-1:0] W_TWO = W_W'(2) << PARAM_FRAC_BITS;

	localparam logic [1:0] MODE_LINEAR  = 2'd0;
	localparam logic [1:0] MODE_BEZIER  = 2'd1;
	localparam logic [1:0] MODE_CATMULL = 2'd2;

	localparam int ADDR_W = 3;
	localparam logic REG_CURVE_MODE = 1'b0;
endpackage

[rtl/core/cse_in_if.sv]
interface cse_in_if;
	logic valid;
	logic ready;
	logic signed [cse_pkg::COORD_W-1:0] before_point;
	logic signed [cse_pkg::COORD_W-1:0] start_point;
	logic signed [cse_pkg::COORD_W-1:0] end_point;
	logic signed [cse_pkg::COORD_W-1:0] after_point;
	logic [cse_pkg::T_W-1:0] param_t;
	logic first_segment;
	logic final_segment;

	modport source (
		output valid, before_point, start_point, end_point, after_point, param_t,
		output first_segment, final_segment,
		input ready
	);
	modport sink (
		input valid, before_point, start_point, end_point, after_point, param_t,
		input first_segment, final_segment,
		output ready
	);
endinterface

[rtl/core/cse_out_if.sv]
interface cse_out_if;
	logic valid;
	logic ready;
	logic signed [cse_pkg::COORD_W-1:0] position;
	logic clipped;

	modport source (output valid, position, clipped, input ready);
	modport sink (input valid, position, clipped, output ready);
endinterface

[rtl/core/curve_segment_evaluator_top.sv]
// Curve segment evaluator: one Q16.16 coordinate of a curve segment at t.
// Input channel "sample" carries the four control points, t (unsigned
// Q1.16, clamped to one) and the first/final segment flags; output channel
// "result" carries the position, saturated in Catmull-Rom mode, and a clipped flag.
// The APB port holds curve_mode at addresses 0 to 3 (0 linear, 1 quadratic
// Bezier, 2 Catmull-Rom, 3 acts as linear); write it only while idle.
// Each transaction runs through a 10-stage pipeline of multipliers and adders,
// stages s1 to s10, the last stage being the output register.
// One transaction can enter every cycle while sample.ready is high.
// Each stage advances when it is empty or the stage after it advances, so
// when the receiver stalls the pipeline fills its bubbles and keeps taking
// transactions until every stage holds one; then sample.ready drops.
// Reset clears all stage valid bits and sets curve_mode to linear.
`include "curve_segment_evaluator_top_assert.svh"

module curve_segment_evaluator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cse_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	cse_in_if.sink                      sample,
	cse_out_if.source                   result
);
	localparam int NSTG = 10;
	localparam int PFB = cse_pkg::PARAM_FRAC_BITS;
	localparam int CW = cse_pkg::COORD_W;
	localparam int TW = cse_pkg::T_W;
	localparam int DW = cse_pkg::D_W;
	localparam int MW = cse_pkg::M_W;
	localparam int TTW = cse_pkg::TT_W;
	localparam int WW = cse_pkg::W_W;
	localparam int PW = cse_pkg::P_W;
	localparam int SW = cse_pkg::S_W;
	localparam logic signed [MW-1:0] M_HALF = MW'(1) << (PFB - 1);
	localparam logic [TTW-1:0] TT_HALF = TTW'(1) << (PFB - 1);
	localparam logic signed [SW-1:0] S_HALF = SW'(1) << PFB;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic [1:0] mode_q;
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[cse_pkg::ADDR_W-1] == cse_pkg::REG_CURVE_MODE) ?
		{30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cse_pkg::MODE_LINEAR;
		end else if (psel && penable && pwrite &&
			paddr[cse_pkg::ADDR_W-1] == cse_pkg::REG_CURVE_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	// stage flow control
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || result.ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign sample.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1 input select
	logic cr_in;
	logic [TW-1:0] t_in;
	logic signed [CW-1:0] pb_in, pa_in;
	logic signed [DW-1:0] d0_in, d1_in;

	always_comb begin
		cr_in = (mode_q == cse_pkg::MODE_CATMULL);
		t_in = (sample.param_t > cse_pkg::T_ONE) ? cse_pkg::T_ONE : sample.param_t;
		pb_in = (cr_in && sample.first_segment) ? sample.start_point : sample.before_point;
		pa_in = (cr_in && sample.final_segment) ? sample.end_point : sample.after_point;
		d0_in = {sample.end_point[CW-1], sample.end_point} -
			{sample.start_point[CW-1], sample.start_point};
		d1_in = {pa_in[CW-1], pa_in} - {sample.end_point[CW-1], sample.end_point};
	end

	logic [1:0] mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic [1:0] mode_s8, mode_s9;
	logic [TW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [CW-1:0] pb_s1, p0_s1, p1_s1, pa_s1;
	logic signed [CW-1:0] pb_s2, p0_s2, p1_s2, pa_s2;
	logic signed [CW-1:0] pb_s3, p0_s3, p1_s3, pa_s3;
	logic signed [CW-1:0] pb_s4, p0_s4, p1_s4, pa_s4;
	logic signed [CW-1:0] pb_s5, p0_s5, p1_s5, pa_s5;
	logic signed [CW-1:0] pb_s6, p0_s6, p1_s6, pa_s6;
	logic signed [DW-1:0] d0_s1, d1_s1;
	logic signed [MW-1:0] m0_s2, m1_s2;
	logic [TTW-1:0] tt_s2;
	logic signed [CW-1:0] a_s3, b_s3, a_s4, a_s5;
	logic [TW-1:0] t2_s3, t2_s4, t2_s5;
	logic signed [DW-1:0] d2_s4;
	logic [TTW-1:0] ttt_s4;
	logic signed [MW-1:0] m2_s5;
	logic [TW-1:0] t3_s5;
	logic signed [CW-1:0] rlb_s6, rlb_s7, rlb_s8, rlb_s9;
	logic signed [WW-1:0] w0_s6, w1_s6, w2_s6, w3_s6;
	logic signed [PW-1:0] pr0_s7, pr1_s7, pr2_s7, pr3_s7;
	logic signed [PW:0] s01_s8, s23_s8;
	logic signed [SW-1:0] sum_s9;
	logic signed [CW-1:0] pos_s10;
	logic clip_s10;

	// stage 3 rounding
	logic signed [MW-1:0] m0r, m1r, m0sh, m1sh;
	logic [TTW-1:0] tt_r;
	always_comb begin
		m0r = m0_s2 + M_HALF;
		m1r = m1_s2 + M_HALF;
		m0sh = m0r >>> PFB;
		m1sh = m1r >>> PFB;
		tt_r = tt_s2 + TT_HALF;
	end

	// stage 5/6 rounding and weights
	logic [TTW-1:0] ttt_r;
	logic signed [MW-1:0] m2r, m2sh;
	logic signed [CW-1:0] bez;
	logic signed [WW-1:0] tw, t2w, t3w;
	always_comb begin
		ttt_r = ttt_s4 + TT_HALF;
		m2r = m2_s5 + M_HALF;
		m2sh = m2r >>> PFB;
		bez = a_s5 + m2sh[CW-1:0];
		tw = WW'(t_s5);
		t2w = WW'(t2_s5);
		t3w = WW'(t3_s5);
	end

	// stage 10 rounding and saturation
	logic signed [SW-1:0] sum_r, q;
	always_comb begin
		sum_r = sum_s9 + S_HALF;
		q = sum_r >>> (PFB + 1);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mode_s1 <= mode_q;
			t_s1 <= t_in;
			pb_s1 <= pb_in;
			p0_s1 <= sample.start_point;
			p1_s1 <= sample.end_point;
			pa_s1 <= pa_in;
			d0_s1 <= d0_in;
			d1_s1 <= d1_in;
		end
		if (adv[1]) begin
			mode_s2 <= mode_s1;
			t_s2 <= t_s1;
			{pb_s2, p0_s2, p1_s2, pa_s2} <= {pb_s1, p0_s1, p1_s1, pa_s1};
			m0_s2 <= d0_s1 * $signed({1'b0, t_s1});
			m1_s2 <= d1_s1 * $signed({1'b0, t_s1});
			tt_s2 <= t_s1 * t_s1;
		end
		if (adv[2]) begin
			mode_s3 <= mode_s2;
			t_s3 <= t_s2;
			{pb_s3, p0_s3, p1_s3, pa_s3} <= {pb_s2, p0_s2, p1_s2, pa_s2};
			a_s3 <= p0_s2 + m0sh[CW-1:0];
			b_s3 <= p1_s2 + m1sh[CW-1:0];
			t2_s3 <= tt_r[PFB +: TW];
		end
		if (adv[3]) begin
			mode_s4 <= mode_s3;
			t_s4 <= t_s3;
			{pb_s4, p0_s4, p1_s4, pa_s4} <= {pb_s3, p0_s3, p1_s3, pa_s3};
			a_s4 <= a_s3;
			d2_s4 <= {b_s3[CW-1], b_s3} - {a_s3[CW-1], a_s3};
			t2_s4 <= t2_s3;
			ttt_s4 <= t2_s3 * t_s3;
		end
		if (adv[4]) begin
			mode_s5 <= mode_s4;
			t_s5 <= t_s4;
			{pb_s5, p0_s5, p1_s5, pa_s5} <= {pb_s4, p0_s4, p1_s4, pa_s4};
			a_s5 <= a_s4;
			m2_s5 <= d2_s4 * $signed({1'b0, t_s4});
			t2_s5 <= t2_s4;
			t3_s5 <= ttt_r[PFB +: TW];
		end
		if (adv[5]) begin
			mode_s6 <= mode_s5;
			{pb_s6, p0_s6, p1_s6, pa_s6} <= {pb_s5, p0_s5, p1_s5, pa_s5};
			rlb_s6 <= (mode_s5 == cse_pkg::MODE_BEZIER) ? bez : a_s5;
			w0_s6 <= -t3w + (t2w <<< 1) - tw;
			w1_s6 <= (t3w * WW'(3)) - (t2w * WW'(5)) + cse_pkg::W_TWO;
			w2_s6 <= tw + (t2w <<< 2) - (t3w * WW'(3));
			w3_s6 <= t3w - t2w;
		end
		if (adv[6]) begin
			mode_s7 <= mode_s6;
			rlb_s7 <= rlb_s6;
			pr0_s7 <= w0_s6 * pb_s6;
			pr1_s7 <= w1_s6 * p0_s6;
			pr2_s7 <= w2_s6 * p1_s6;
			pr3_s7 <= w3_s6 * pa_s6;
		end
		if (adv[7]) begin
			mode_s8 <= mode_s7;
			rlb_s8 <= rlb_s7;
			s01_s8 <= (PW+1)'(pr0_s7) + (PW+1)'(pr1_s7);
			s23_s8 <= (PW+1)'(pr2_s7) + (PW+1)'(pr3_s7);
		end
		if (adv[8]) begin
			mode_s9 <= mode_s8;
			rlb_s9 <= rlb_s8;
			sum_s9 <= SW'(s01_s8) + SW'(s23_s8);
		end
		if (adv[9]) begin
			if (mode_s9 == cse_pkg::MODE_CATMULL) begin
				if (q > SAT_HI) begin
					pos_s10 <= SAT_HI[CW-1:0];
					clip_s10 <= 1'b1;
				end else if (q < SAT_LO) begin
					pos_s10 <= SAT_LO[CW-1:0];
					clip_s10 <= 1'b1;
				end else begin
					pos_s10 <= q[CW-1:0];
					clip_s10 <= 1'b0;
				end
			end else begin
				pos_s10 <= rlb_s9;
				clip_s10 <= 1'b0;
			end
		end
	end

	assign result.valid = vld_q[NSTG-1];
	assign result.position = pos_s10;
	assign result.clipped = clip_s10;

	`CSE_ASSERT(a_full_when_blocked, !sample.ready |-> (result.valid && !result.ready))
	`CSE_ASSERT_NEXT(a_occupancy, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + $past(sample.valid && sample.ready && arst_n) - $past(result.valid && result.ready))
	`CSE_ASSERT(a_weight_unity, vld_q[5] |-> ((w0_s6 + w1_s6 + w2_s6 + w3_s6) == cse_pkg::W_TWO))
	`CSE_ASSERT(a_t_clamped, vld_q[2] |-> (t_s3 <= cse_pkg::T_ONE && t2_s3 <= cse_pkg::T_ONE))
endmodule
